// ===== hdl/eds_pkg.sv =====
// Shared types and constants for the five-point diffusion stencil core.
package eds_pkg;

  localparam int MAX_LINE   = 1024;
  localparam int DEPTH_W    = 16;
  localparam int COEF_W     = 16;
  localparam int COL_W      = $clog2(MAX_LINE);
  localparam int LEN_W      = 11;
  localparam int CNT_W      = 16;
  localparam int CEN_W      = 16;
  localparam int NBR_W      = 15;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_CENTER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_ACROSS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_ALONG  = 3'd4;

  localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(3);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LINE);
  localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(3);

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic [COL_W-1:0]   col;
    logic               emit;
    logic               last;
  } eds_item_t;

  typedef struct packed {
    logic [CEN_W-1:0] center;
    logic [NBR_W-1:0] across;
    logic [NBR_W-1:0] along;
  } eds_coef_t;

endpackage

// ===== hdl/explicit_diffusion_stencil_core.sv =====
// Top level of the five-point explicit diffusion stencil core.
// A result leaves the output register after the cell one line down, one column right of it,
// passes the queue, line-store read, window and product registers; out_ready low stalls it.
// Throughput: one cell per cycle when unstalled, set by one read and write port per store.
// Reset (synchronous, rst_n low): counters, queue, window and valids cleared, registers
// take their reset values; the line stores are not cleared and hold nothing until written.
module explicit_diffusion_stencil_core import eds_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [DEPTH_W-1:0]   in_water_depth,
  input  logic                 in_frame_start,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DEPTH_W-1:0]   out_new_depth,
  output logic                 out_frame_last
);

  logic [LEN_W-1:0] line_length_r;
  logic [CNT_W-1:0] line_count_r;
  eds_coef_t        coef_r;
  logic [LEN_W-1:0] eff_len;
  logic [CNT_W-1:0] eff_cnt;

  logic      full, take, head_valid, pop;
  eds_item_t front_item, head_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_length_r <= LEN_W'(1024);
      line_count_r  <= CNT_W'(1024);
      coef_r.center <= CEN_W'(32768);
      coef_r.across <= NBR_W'(8192);
      coef_r.along  <= NBR_W'(8192);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LINE_LENGTH: line_length_r <= cfg_wdata[LEN_W-1:0];
        REG_LINE_COUNT:  line_count_r  <= cfg_wdata[CNT_W-1:0];
        REG_COEF_CENTER: coef_r.center <= cfg_wdata[CEN_W-1:0];
        REG_COEF_ACROSS: coef_r.across <= cfg_wdata[NBR_W-1:0];
        REG_COEF_ALONG:  coef_r.along  <= cfg_wdata[NBR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (line_length_r < LEN_MIN) begin
      eff_len = LEN_MIN;
    end else if (line_length_r > LEN_MAX) begin
      eff_len = LEN_MAX;
    end else begin
      eff_len = line_length_r;
    end
    eff_cnt = (line_count_r < CNT_MIN) ? CNT_MIN : line_count_r;
  end

  assign in_ready = !full;
  assign take     = in_valid && !full;

  eds_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .eff_len     (eff_len),
    .eff_cnt     (eff_cnt),
    .take        (take),
    .depth       (in_water_depth),
    .frame_start (in_frame_start),
    .item        (front_item)
  );

  eds_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (take),
    .push_item  (front_item),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  eds_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .coef           (coef_r),
    .head_valid     (head_valid),
    .head_item      (head_item),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_new_depth  (out_new_depth),
    .out_frame_last (out_frame_last)
  );

endmodule

// ===== hdl/eds_front.sv =====
// Front end: raster position tracking and interior/last-cell classification.
module eds_front import eds_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [LEN_W-1:0]   eff_len,
  input  logic [CNT_W-1:0]   eff_cnt,
  input  logic               take,
  input  logic [DEPTH_W-1:0] depth,
  input  logic               frame_start,
  output eds_item_t          item
);

  logic [COL_W-1:0] col_r, col_nxt, col_cur;
  logic [CNT_W-1:0] row_r, row_nxt, row_cur;
  logic [LEN_W-1:0] col_inc;
  logic [CNT_W:0]   row_inc;

  always_comb begin
    col_cur = frame_start ? '0 : col_r;
    row_cur = frame_start ? '0 : row_r;
    col_inc = {1'b0, col_cur} + LEN_W'(1);
    row_inc = {1'b0, row_cur} + (CNT_W+1)'(1);

    item.depth = depth;
    item.col   = col_cur;
    item.emit  = (row_cur >= CNT_W'(2)) && (col_cur >= COL_W'(2)) &&
                 ({1'b0, col_cur} < eff_len) && (row_cur < eff_cnt);
    item.last  = (row_inc == {1'b0, eff_cnt}) && (col_inc == eff_len);

    col_nxt = col_r;
    row_nxt = row_r;
    if (take) begin
      if (col_inc >= eff_len) begin
        col_nxt = '0;
        row_nxt = (row_inc >= {1'b0, eff_cnt}) ? '0 : row_inc[CNT_W-1:0];
      end else begin
        col_nxt = col_inc[COL_W-1:0];
        row_nxt = row_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// ===== hdl/eds_fifo.sv =====
// Short queue between classification front end and stencil back end.
module eds_fifo import eds_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  eds_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output eds_item_t head_item
);

  eds_item_t          mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;

  assign full       = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_item  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + FIFO_AW'(1) : wp_r;
    rp_nxt  = pop ? rp_r + FIFO_AW'(1) : rp_r;
    cnt_nxt = cnt_r + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("queue occupancy beyond depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !head_valid))
    else $error("pop from empty queue");
`endif

endmodule

// ===== hdl/eds_back.sv =====
// Back end: line stores, 3x3 window, weighted sum, rounding and output register.
module eds_back import eds_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  eds_coef_t          coef,
  input  logic               head_valid,
  input  eds_item_t          head_item,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [DEPTH_W-1:0] out_new_depth,
  output logic               out_frame_last
);

  localparam int SUM_W  = DEPTH_W + 1;
  localparam int PROD_W = COEF_W + SUM_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam logic [ACC_W-1:0] ROUND = ACC_W'(1) << (COEF_W - 1);

  logic [DEPTH_W-1:0] store_upper [MAX_LINE];
  logic [DEPTH_W-1:0] store_middle [MAX_LINE];

  logic               adv;
  logic               s1_valid_r;
  eds_item_t          s1_item_r;
  logic [DEPTH_W-1:0] up_rd_r, mid_rd_r;
  logic               fwd_r;
  logic [DEPTH_W-1:0] fwd_up_r, fwd_mid_r;
  logic [DEPTH_W-1:0] up_eff, mid_eff;

  logic [DEPTH_W-1:0] w_above_r, w_left_r, w_center_r, w_below_r;

  logic               s2_valid_r, s2_emit_r, s2_last_r;
  logic [PROD_W-1:0]  p_center_r, p_across_r, p_along_r;
  logic [ACC_W-1:0]   acc;

  logic               out_valid_r, out_valid_nxt;
  logic [DEPTH_W-1:0] out_depth_r;
  logic               out_last_r;

  assign adv = !out_valid_r || out_ready;
  assign pop = adv && head_valid;

  assign up_eff  = fwd_r ? fwd_up_r  : up_rd_r;
  assign mid_eff = fwd_r ? fwd_mid_r : mid_rd_r;

  // line stores: read-before-write, same-column back-to-back covered by forwarding
  always_ff @(posedge clk) begin
    if (adv) begin
      up_rd_r  <= store_upper[head_item.col];
      mid_rd_r <= store_middle[head_item.col];
    end
    if (adv && s1_valid_r) begin
      store_upper[s1_item_r.col]  <= mid_eff;
      store_middle[s1_item_r.col] <= s1_item_r.depth;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item_r <= head_item;
      fwd_up_r  <= mid_eff;
      fwd_mid_r <= s1_item_r.depth;
      s2_emit_r <= s1_item_r.emit;
      s2_last_r <= s1_item_r.last;
      p_center_r <= PROD_W'(coef.center) * PROD_W'(w_center_r);
      p_across_r <= PROD_W'(coef.across) * PROD_W'(SUM_W'(w_above_r) + SUM_W'(w_below_r));
      p_along_r  <= PROD_W'(coef.along) * PROD_W'(SUM_W'(w_left_r) + SUM_W'(mid_eff));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
      s2_valid_r <= 1'b0;
      w_above_r  <= '0;
      w_left_r   <= '0;
      w_center_r <= '0;
      w_below_r  <= '0;
    end else if (adv) begin
      s1_valid_r <= head_valid;
      fwd_r      <= s1_valid_r && head_valid && (s1_item_r.col == head_item.col);
      s2_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        w_above_r  <= up_eff;
        w_left_r   <= w_center_r;
        w_center_r <= mid_eff;
        w_below_r  <= s1_item_r.depth;
      end
    end
  end

  assign acc = ACC_W'(p_center_r) + ACC_W'(p_across_r) + ACC_W'(p_along_r) + ROUND;
  assign out_valid_nxt = adv ? (s2_valid_r && s2_emit_r) : out_valid_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_depth_r <= (|acc[ACC_W-1:COEF_W+DEPTH_W]) ? {DEPTH_W{1'b1}}
                                                   : acc[COEF_W+DEPTH_W-1:COEF_W];
      out_last_r  <= s2_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_new_depth  = out_depth_r;
  assign out_frame_last = out_last_r;

`ifndef ASSERT_OFF
  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s2_valid_r && s2_emit_r |=> out_valid_r)
    else $error("interior result lost before output register");
  a_fwd_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> s1_valid_r)
    else $error("forwarding flagged without an item in the read stage");
`endif

endmodule
